// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file of the list block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, quiet in reset
`define AST_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, quiet in reset
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/core/alc_pkg.sv =====
// Shared types and constants of the ordered list block.
package alc_pkg;

    localparam int DATA_W    = 32;
    localparam int ACT_W     = 3;
    localparam int POS_W     = 5;
    localparam int CNT_OUT_W = 5;
    localparam int STAT_W    = 2;
    localparam int IN_W      = 40;
    localparam int OUT_W     = 48;

    typedef enum logic [ACT_W-1:0] {
        ACT_INS_FRONT = 3'd0,
        ACT_INS_POS   = 3'd1,
        ACT_INS_END   = 3'd2,
        ACT_DEL_FRONT = 3'd3,
        ACT_DEL_END   = 3'd4,
        ACT_DEL_POS   = 3'd5,
        ACT_PEEK      = 3'd6
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // Broadcast shift command for the row of cells
    typedef struct packed {
        logic ins;
        logic del;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/alc_cell.sv =====
// One storage cell of the list: holds an entry, shifts up or down with its neighbours.
module alc_cell
    import alc_pkg::*;
#(
    parameter int IW  = 4,
    parameter int IDX = 0
)
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [IW-1:0]     at,
    input  logic [DATA_W-1:0] value,
    input  logic [DATA_W-1:0] prev_data,
    input  logic [DATA_W-1:0] next_data,
    output logic [DATA_W-1:0] data,
    output logic [DATA_W-1:0] rd_data
);

    localparam logic [IW-1:0] IDX_V = IW'(IDX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    // Take the left neighbour above an insert point, the value at it, the right one from a delete point
    always_comb
    begin
        data_next = data_reg;
        priority if (ctrl.ins && (IDX_V > at))
            data_next = prev_data;
        else if (ctrl.ins && (IDX_V == at))
            data_next = value;
        else if (ctrl.del && (IDX_V >= at))
            data_next = next_data;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    // Drive the read bus only when this cell is addressed
    assign rd_data = (IDX_V == at) ? data_reg : '0;

endmodule

// ===== rtl/core/array_list_insert_delete.sv =====
// Ordered list of signed words in a row of shifting cells, with insert, delete and peek.
// Each request is one transaction on the slave side and yields one result transaction on
// the master side in the next cycle; a new request is taken every cycle while the result
// register is empty or being drained, so the rate is one request per cycle, set by the
// single result register. The cells from the position upward shift together in the cycle
// of acceptance, so inserts and deletes work at any position. Entries above the element
// count are never read and carry no reset. Counts and free slots are reported modulo 32.
module array_list_insert_delete
    import alc_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // action[2:0], value[34:3], position[39:35]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // status[1:0], element_count[6:2],
                                        // free_slots[11:7], is_full[12], is_empty[13],
                                        // read_value[45:14], zero[47:46]
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int IW    = $clog2(CAPACITY);
    localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

    action_t           act;
    logic [DATA_W-1:0] val;
    logic [POS_W-1:0]  pos;
    logic [CMP_W-1:0]  pos_c;
    logic [CMP_W-1:0]  cnt_c;
    logic              fire;
    logic              full;
    logic              empty;

    status_t           status_c;
    logic              ins_c;
    logic              del_c;
    logic              dec_c;
    logic              rd_ok_c;
    logic [IW-1:0]     at_c;
    cell_ctrl_t        ctrl;

    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [CW-1:0]     free_c;

    logic [DATA_W-1:0] cell_q  [CAPACITY];
    logic [DATA_W-1:0] cell_rd [CAPACITY];
    logic [DATA_W-1:0] rd_bus;

    logic              m_tvalid_reg;
    status_t           status_reg;
    logic [CNT_OUT_W-1:0] cnt_out_reg;
    logic [CNT_OUT_W-1:0] free_out_reg;
    logic              full_reg;
    logic              empty_reg;
    logic [DATA_W-1:0] rd_reg;

    // Unpack the request
    assign act   = action_t'(s_tdata[2:0]);
    assign val   = s_tdata[34:3];
    assign pos   = s_tdata[39:35];
    assign pos_c = CMP_W'(pos);
    assign cnt_c = CMP_W'(count_reg);
    assign full  = (count_reg == CW'(CAPACITY));
    assign empty = (count_reg == '0);

    assign s_tready = !m_tvalid_reg || m_tready;
    assign fire     = s_tvalid && s_tready;

    // Decode the request and check it against the current count
    always_comb
    begin
        status_c = ST_OK;
        ins_c    = 1'b0;
        del_c    = 1'b0;
        dec_c    = 1'b0;
        rd_ok_c  = 1'b0;
        at_c     = '0;
        unique case (act)
            ACT_INS_FRONT:
            begin
                if (full) status_c = ST_FULL;
                else      ins_c    = 1'b1;
            end
            ACT_INS_POS:
            begin
                at_c = IW'(pos);
                priority if (full)         status_c = ST_FULL;
                else if (pos_c > cnt_c)    status_c = ST_RANGE;
                else                       ins_c    = 1'b1;
            end
            ACT_INS_END:
            begin
                at_c = IW'(count_reg);
                if (full) status_c = ST_FULL;
                else      ins_c    = 1'b1;
            end
            ACT_DEL_FRONT:
            begin
                if (empty) status_c = ST_EMPTY;
                else       del_c    = 1'b1;
            end
            ACT_DEL_END:
            begin
                if (empty) status_c = ST_EMPTY;
                else       dec_c    = 1'b1;
            end
            ACT_DEL_POS:
            begin
                at_c = IW'(pos);
                priority if (empty)        status_c = ST_EMPTY;
                else if (pos_c >= cnt_c)   status_c = ST_RANGE;
                else                       del_c    = 1'b1;
            end
            ACT_PEEK:
            begin
                at_c = IW'(pos);
                priority if (empty)        status_c = ST_EMPTY;
                else if (pos_c >= cnt_c)   status_c = ST_RANGE;
                else                       rd_ok_c  = 1'b1;
            end
            default: ;
        endcase
    end

    assign ctrl.ins = fire && ins_c;
    assign ctrl.del = fire && del_c;

    // Advance the element count
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.ins)
            count_next = count_reg + CW'(1);
        else if (ctrl.del || (fire && dec_c))
            count_next = count_reg - CW'(1);
    end

    assign free_c = CW'(CAPACITY) - count_next;

    // Row of storage cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] prev_w;
        logic [DATA_W-1:0] next_w;

        if (i == 0)
        begin : g_first
            assign prev_w = '0;
        end
        else
        begin : g_inner_prev
            assign prev_w = cell_q[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_w = cell_q[i];
        end
        else
        begin : g_inner_next
            assign next_w = cell_q[i+1];
        end

        alc_cell #(
            .IW  (IW),
            .IDX (i)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .at        (at_c),
            .value     (val),
            .prev_data (prev_w),
            .next_data (next_w),
            .data      (cell_q[i]),
            .rd_data   (cell_rd[i])
        );
    end

    // Merge the one addressed cell onto the read bus
    always_comb
    begin
        rd_bus = '0;
        for (int k = 0; k < CAPACITY; k++)
            rd_bus = rd_bus | cell_rd[k];
    end

    // Hold control state and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (fire)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg   <= status_c;
            cnt_out_reg  <= CNT_OUT_W'(count_next);
            free_out_reg <= CNT_OUT_W'(free_c);
            full_reg     <= (count_next == CW'(CAPACITY));
            empty_reg    <= (count_next == '0);
            rd_reg       <= rd_ok_c ? rd_bus : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, rd_reg, empty_reg, full_reg, free_out_reg, cnt_out_reg,
                       status_reg};

endmodule

// ===== rtl/core/alc_checker.sv =====
// Port-level checker for the ordered list block, bound to its top level.
`include "assert_macros.svh"

module alc_checker
    import alc_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    localparam logic [CNT_OUT_W-1:0] CAP_MOD = CNT_OUT_W'(CAPACITY);

    // Every accepted request yields a result in the next cycle
    `AST_NEXT(a_req_to_res, s_tvalid && s_tready, m_tvalid)
    // Stalled result holds
    `AST_NEXT(a_res_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // Count and free slots always make up the capacity
    `AST_IMPLY(a_cnt_free, m_tvalid, CNT_OUT_W'(m_tdata[6:2] + m_tdata[11:7]) == CAP_MOD)
    // A rejected insert reports a full list
    `AST_IMPLY(a_full_flag, m_tvalid && (m_tdata[1:0] == ST_FULL), m_tdata[12])
    // A rejected delete or peek reports an empty list with no data
    `AST_IMPLY(a_empty_flag, m_tvalid && (m_tdata[1:0] == ST_EMPTY),
               m_tdata[13] && (m_tdata[45:14] == '0))

endmodule

bind array_list_insert_delete alc_checker #(.CAPACITY(CAPACITY)) u_alc_checker (.*);
